/* hw/rtl/sts_pkg.sv */
// Shared types, constants and fixed-point helpers for the simplex solver.
// No dependencies; used by every module of the solver.
package sts_pkg;

  localparam int MaxCons = 16;
  localparam int MaxCols = 64;
  localparam int NRows   = MaxCons + 2;
  localparam int MaxIter = 4000;

  localparam int RowW  = 5;
  localparam int ColW  = 6;
  localparam int AddrW = 11;
  localparam int DW    = 48;
  localparam int TabDepth = NRows * MaxCols;

  localparam logic signed [DW-1:0] QMax = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] QMin = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_TAB   = 2'd0,
    REQ_BASIS = 2'd1,
    REQ_START = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OPTIMAL = 2'd0,
    ST_NOROW   = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_INFEAS  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_CONS = 3'd0,
    CFG_ROWS = 3'd1,
    CFG_COLS = 3'd2,
    CFG_OROW = 3'd3,
    CFG_ART  = 3'd4,
    CFG_TOL  = 3'd5
  } cfg_idx_t;

  // Divider handshake
  typedef struct packed {
    logic                 go;
    logic signed [DW-1:0] num;
    logic signed [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] quo;
  } div_rsp_t;

  function automatic logic [AddrW-1:0] taddr(input logic [RowW-1:0] r,
                                             input logic [ColW-1:0] c);
    taddr = AddrW'({r, c});
  endfunction

  function automatic logic signed [DW-1:0] sat_from(input logic signed [DW+1:0] x);
    if (x > $signed({{2{1'b0}}, QMax})) sat_from = QMax;
    else if (x < $signed({{2{1'b1}}, QMin})) sat_from = QMin;
    else sat_from = x[DW-1:0];
  endfunction

  // Saturating signed value from magnitude and sign
  function automatic logic signed [DW-1:0] sgn_sat(input logic [DW:0] m, input logic neg);
    if (neg) begin
      if (m > {1'b0, 1'b1, {(DW-1){1'b0}}}) sgn_sat = QMin;
      else sgn_sat = DW'(-m);
    end else begin
      if (m > {2'b00, {(DW-1){1'b1}}}) sgn_sat = QMax;
      else sgn_sat = m[DW-1:0];
    end
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
    mag = x[DW-1] ? DW'(-x) : x;
  endfunction

endpackage

/* hw/rtl/simplex_tableau_solver_unit.sv */
// Simplex tableau solver: top level with tableau memories and pivot sequencer.
// Depends on sts_pkg, sts_div and sts_mul.
//
// Use: load tableau entries (in_req_type 0) and basis slots (in_req_type 1)
// with start while busy is low, one beat per cycle. A start beat
// (in_req_type 2) copies the stored tableau to a working memory and runs the
// simplex loop; busy stays high until the last result has been shown.
// Results appear one per cycle on out_* with out_valid; out_last marks the
// final one. Either one failure beat or one beat per constraint row.
// Run time is set by the single-port working memory and the serial divider:
// each pass does one divide per pivot row entry and per ratio test row and
// one read-modify-write per entry otherwise, plus a copy of rows*64 entries
// at start.
// Configuration writes go through cfg_valid/cfg_ready, ready whenever idle.
// Synchronous reset clears the sequencer state and the configuration registers to their defaults;
// memories hold no reset value. The receiver cannot stall results.
module simplex_tableau_solver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [4:0]  in_row_index,
  input  logic [5:0]  in_column_index,
  input  logic signed [47:0] in_entry_value,
  input  logic [5:0]  in_basis_column,
  output logic        out_valid,
  output logic [3:0]  out_result_row,
  output logic [5:0]  out_result_basis,
  output logic signed [47:0] out_rhs_value,
  output logic signed [47:0] out_objective_value,
  output logic [1:0]  out_status,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data
);
  typedef enum logic [4:0] {
    S_IDLE, S_COPY, S_CSCAN, S_CDEC, S_RSCAN, S_RDIV, S_RWAIT, S_RDEC,
    S_PDIV, S_PWAIT, S_PWR, S_EF, S_EREAD, S_EMUL, S_EWR, S_NEXTROW,
    S_ART, S_ASCAN, S_ACHK, S_EMIT, S_FAIL
  } st_t;

  localparam int AW = sts_pkg::AddrW;

  // configuration
  logic [4:0] cons_r, rows_r, orow_r;
  logic [6:0] cols_r;
  logic       art_r;
  logic [24:0] tol_r;

  // memories
  logic signed [47:0] stor_mem [sts_pkg::TabDepth];
  logic signed [47:0] work_mem [sts_pkg::TabDepth];
  logic [5:0] basis_mem [sts_pkg::MaxCons];
  logic [5:0] wb_r [sts_pkg::MaxCons];
  logic signed [47:0] stor_q, work_q;
  logic [AW-1:0] s_raddr, w_addr;
  logic w_we;
  logic signed [47:0] w_wd;

  st_t st_r, st_nxt;
  logic [4:0] nr_r, nm_r, ob_r, i_r, i_nxt, prow_r, prow_nxt, row_r, row_nxt;
  logic [4:0] arow_r, arow_nxt;
  logic [6:0] nc_r;
  logic [5:0] k_r, k_nxt, pcol_r, pcol_nxt, nn_r;
  logic [4:0] j_r, j_nxt;
  logic [11:0] it_r, it_nxt;
  logic signed [47:0] best_r, best_nxt, rbest_r, rbest_nxt, c_r, c_nxt;
  logic signed [47:0] f_r, f_nxt, pv_r, pv_nxt, bv_r, bv_nxt;
  logic hc_r, hc_nxt, hr_r, hr_nxt, ph_r, ph_nxt, art_ph_r, art_ph_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [1:0] stat_r, stat_nxt;
  logic [2:0] mw_r, mw_nxt;
  logic copy_we_r;
  logic [AW-1:0] copy_a_r;

  sts_pkg::div_req_t dreq;
  sts_pkg::div_rsp_t drsp;
  logic signed [47:0] mp;
  logic signed [47:0] ma_r;

  sts_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  sts_mul u_mul (.clk(clk), .a(f_r), .b(ma_r), .p(mp));

  wire in_acc = start && !busy;
  wire signed [47:0] tol_s = {23'd0, tol_r};

  // configuration registers
  assign cfg_ready = (st_r == S_IDLE);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cons_r <= 5'd1; rows_r <= 5'd2; cols_r <= 7'd2; orow_r <= 5'd1;
      art_r <= 1'b0; tol_r <= 25'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (sts_pkg::cfg_idx_t'(cfg_index))
        sts_pkg::CFG_CONS: cons_r <= cfg_data[4:0];
        sts_pkg::CFG_ROWS: rows_r <= cfg_data[4:0];
        sts_pkg::CFG_COLS: cols_r <= cfg_data[6:0];
        sts_pkg::CFG_OROW: orow_r <= cfg_data[4:0];
        sts_pkg::CFG_ART:  art_r  <= cfg_data[0];
        sts_pkg::CFG_TOL:  tol_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stored tableau and basis
  always_ff @(posedge clk) begin
    if (in_acc && in_req_type == sts_pkg::REQ_TAB && in_row_index < 5'(sts_pkg::NRows))
      stor_mem[sts_pkg::taddr(in_row_index, in_column_index)] <= in_entry_value;
    if (in_acc && in_req_type == sts_pkg::REQ_BASIS && in_row_index < 5'(sts_pkg::MaxCons))
      basis_mem[in_row_index[3:0]] <= in_basis_column;
    stor_q <= stor_mem[s_raddr];
  end

  // working tableau, single port
  always_ff @(posedge clk) begin
    if (w_we) work_mem[w_addr] <= w_wd;
    work_q <= work_mem[w_addr];
  end

  // clamped sizes
  logic [4:0] nr_c, nm_c, ob_c;
  logic [6:0] nc_c;
  always_comb begin
    nr_c = rows_r < 5'd2 ? 5'd2 : (rows_r > 5'd18 ? 5'd18 : rows_r);
    nc_c = cols_r < 7'd2 ? 7'd2 : (cols_r > 7'd64 ? 7'd64 : cols_r);
    nm_c = cons_r < 5'd1 ? 5'd1 : (cons_r > 5'd16 ? 5'd16 : cons_r);
    if (nm_c > nr_c) nm_c = nr_c;
    ob_c = orow_r > nr_c - 5'd1 ? nr_c - 5'd1 : orow_r;
  end

  wire [5:0] nv = 6'(nc_r - 7'd1);
  logic in_b;
  always_comb begin
    in_b = 1'b0;
    for (int s = 0; s < sts_pkg::MaxCons; s++)
      if (5'(s) < nm_r && wb_r[s] == k_r) in_b = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
    i_r <= i_nxt; k_r <= k_nxt; j_r <= j_nxt; prow_r <= prow_nxt; row_r <= row_nxt;
    pcol_r <= pcol_nxt; best_r <= best_nxt; rbest_r <= rbest_nxt; c_r <= c_nxt;
    f_r <= f_nxt; pv_r <= pv_nxt; bv_r <= bv_nxt; hc_r <= hc_nxt; hr_r <= hr_nxt;
    sub_r <= sub_nxt; stat_r <= stat_nxt; mw_r <= mw_nxt; it_r <= it_nxt;
    ph_r <= ph_nxt; arow_r <= arow_nxt; art_ph_r <= art_ph_nxt;
    ma_r <= work_q;
    copy_we_r <= (st_r == S_COPY) && (sub_r == 2'd1);
    copy_a_r <= s_raddr;
    if (in_acc && in_req_type == sts_pkg::REQ_START) begin
      nr_r <= nr_c; nc_r <= nc_c; nm_r <= nm_c; ob_r <= ob_c;
      nn_r <= (6'(nc_c - 7'd1) > 6'(nm_c)) ? 6'(nc_c - 7'd1) - 6'(nm_c) : 6'd0;
      for (int s = 0; s < sts_pkg::MaxCons; s++) wb_r[s] <= basis_mem[s];
    end else if (st_r == S_PWR && k_r == 6'd0 && sub_r == 2'd0) begin
      wb_r[prow_r[3:0]] <= pcol_r;
    end
  end

  // sequencer
  always_comb begin
    st_nxt = st_r; i_nxt = i_r; k_nxt = k_r; j_nxt = j_r; prow_nxt = prow_r;
    row_nxt = row_r; pcol_nxt = pcol_r; best_nxt = best_r; rbest_nxt = rbest_r;
    c_nxt = c_r; f_nxt = f_r; pv_nxt = pv_r; bv_nxt = bv_r; hc_nxt = hc_r;
    hr_nxt = hr_r; sub_nxt = sub_r; stat_nxt = stat_r; mw_nxt = mw_r; it_nxt = it_r;
    ph_nxt = ph_r; arow_nxt = arow_r; art_ph_nxt = art_ph_r;
    s_raddr = sts_pkg::taddr(i_r, k_r);
    w_addr = sts_pkg::taddr(i_r, k_r); w_we = 1'b0; w_wd = stor_q;
    dreq = '0;
    busy = (st_r != S_IDLE);
    out_valid = 1'b0; out_result_row = 4'd0; out_result_basis = 6'd0;
    out_rhs_value = '0; out_objective_value = '0; out_status = 2'd0; out_last = 1'b0;
    if (copy_we_r) begin
      w_we = 1'b1; w_addr = copy_a_r; w_wd = stor_q;
    end
    case (st_r)
      S_IDLE: if (in_acc && in_req_type == sts_pkg::REQ_START) begin
        st_nxt = S_COPY; i_nxt = 5'd0; k_nxt = 6'd0; sub_nxt = 2'd1; it_nxt = 12'd0;
      end
      // stream stored tableau into working memory
      S_COPY: begin
        if (sub_r == 2'd1) begin
          if (k_r == 6'd63) begin
            k_nxt = 6'd0;
            if (i_r == nr_r - 5'd1) sub_nxt = 2'd2; else i_nxt = i_r + 5'd1;
          end else k_nxt = k_r + 6'd1;
        end else begin
          st_nxt = S_CSCAN; k_nxt = 6'd0; hc_nxt = 1'b0; sub_nxt = 2'd0;
        end
      end
      // column choice: read objective row entry k
      S_CSCAN: begin
        if (it_r == 12'(sts_pkg::MaxIter - 1)) begin
          st_nxt = S_FAIL; stat_nxt = sts_pkg::ST_TIMEOUT;
        end else begin
          w_addr = sts_pkg::taddr(ob_r, k_r); st_nxt = S_CDEC;
        end
      end
      S_CDEC: begin
        if (work_q > tol_s && (!hc_r || work_q > best_r)) begin
          best_nxt = work_q; pcol_nxt = k_r; hc_nxt = 1'b1;
        end
        if (k_r + 6'd1 >= nv) begin
          if (!(work_q > tol_s && (!hc_r || work_q > best_r)) && !hc_r) begin
            st_nxt = art_r ? S_ART : S_EMIT; i_nxt = 5'd0; ph_nxt = 1'b0;
          end else begin
            st_nxt = S_RSCAN; i_nxt = 5'd0; hr_nxt = 1'b0; sub_nxt = 2'd0;
          end
        end else begin
          k_nxt = k_r + 6'd1; st_nxt = S_CSCAN;
        end
      end
      // ratio test: read b then c for row i
      S_RSCAN: begin
        if (sub_r == 2'd0) begin
          w_addr = sts_pkg::taddr(i_r, pcol_r); sub_nxt = 2'd1;
        end else begin
          w_addr = sts_pkg::taddr(i_r, nv); bv_nxt = work_q; st_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        c_nxt = work_q;
        if (work_q < -tol_s || bv_r < tol_s || bv_r == '0) st_nxt = S_RDEC;
        else begin
          dreq.go = 1'b1; dreq.num = work_q; dreq.den = bv_r; st_nxt = S_RWAIT;
        end
        sub_nxt = 2'd2;
      end
      S_RWAIT: if (drsp.done) begin
        if (!hr_r || drsp.quo < rbest_r) begin
          rbest_nxt = drsp.quo; row_nxt = i_r; hr_nxt = 1'b1;
        end
        st_nxt = S_RDEC;
      end
      S_RDEC: begin
        sub_nxt = 2'd0;
        if (i_r + 5'd1 >= nm_r) begin
          if (!hr_r) begin st_nxt = S_FAIL; stat_nxt = sts_pkg::ST_NOROW; end
          else begin
            prow_nxt = row_r; st_nxt = S_PDIV; k_nxt = 6'd0;
          end
        end else begin i_nxt = i_r + 5'd1; st_nxt = S_RSCAN; end
      end
      // pivot: read pivot value, then divide row entries
      S_PDIV: begin
        if (sub_r == 2'd0) begin
          w_addr = sts_pkg::taddr(prow_r, pcol_r); sub_nxt = 2'd1;
        end else if (sub_r == 2'd1) begin
          pv_nxt = work_q; sub_nxt = 2'd2;
          w_addr = sts_pkg::taddr(prow_r, k_r);
        end else begin
          w_addr = sts_pkg::taddr(prow_r, k_r); sub_nxt = 2'd3; st_nxt = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (sub_r == 2'd3) begin
          dreq.go = 1'b1; dreq.num = work_q; dreq.den = pv_r; sub_nxt = 2'd1;
        end else if (drsp.done) begin
          c_nxt = drsp.quo; st_nxt = S_PWR; sub_nxt = 2'd0;
        end
      end
      S_PWR: begin
        w_addr = sts_pkg::taddr(prow_r, k_r); w_we = 1'b1; w_wd = c_r;
        if (7'(k_r) + 7'd1 >= nc_r) begin
          st_nxt = S_EF; j_nxt = 5'd0; sub_nxt = 2'd0;
        end else begin
          k_nxt = k_r + 6'd1; st_nxt = S_PDIV; sub_nxt = 2'd2;
        end
      end
      // elimination: fetch factor of row j
      S_EF: begin
        if (j_r == prow_r) st_nxt = S_NEXTROW;
        else if (sub_r == 2'd0) begin
          w_addr = sts_pkg::taddr(j_r, pcol_r); sub_nxt = 2'd1;
        end else begin
          f_nxt = work_q; k_nxt = 6'd0; st_nxt = S_EREAD; sub_nxt = 2'd0;
        end
      end
      // read pivot row entry, multiply, read target, write difference
      S_EREAD: begin
        w_addr = sts_pkg::taddr(prow_r, k_r); st_nxt = S_EMUL; mw_nxt = 3'd0;
      end
      S_EMUL: begin
        w_addr = sts_pkg::taddr(j_r, k_r);
        mw_nxt = mw_r + 3'd1;
        if (mw_r == 3'd0) c_nxt = '0;
        if (mw_r == 3'd1) c_nxt = work_q;
        if (mw_r == 3'd3) st_nxt = S_EWR;
      end
      S_EWR: begin
        w_addr = sts_pkg::taddr(j_r, k_r); w_we = 1'b1;
        w_wd = sts_pkg::sat_from(50'(c_r) - 50'(mp));
        if (7'(k_r) + 7'd1 >= nc_r) st_nxt = S_NEXTROW;
        else begin k_nxt = k_r + 6'd1; st_nxt = S_EREAD; end
      end
      S_NEXTROW: begin
        sub_nxt = 2'd0;
        if (j_r + 5'd1 >= nr_r) begin
          if (art_ph_r) begin
            st_nxt = S_ACHK; art_ph_nxt = 1'b0;
          end else begin
            it_nxt = it_r + 12'd1; st_nxt = S_CSCAN; k_nxt = 6'd0; hc_nxt = 1'b0;
          end
        end else begin j_nxt = j_r + 5'd1; st_nxt = S_EF; end
      end
      // phase-1 check on last row RHS
      S_ART: begin
        if (sub_r == 2'd0) begin
          w_addr = sts_pkg::taddr(nr_r - 5'd1, nv); sub_nxt = 2'd1;
        end else begin
          sub_nxt = 2'd0;
          if (!({1'b0, sts_pkg::mag(work_q)} < {24'd0, tol_r})) begin
            st_nxt = S_FAIL; stat_nxt = sts_pkg::ST_INFEAS;
          end else begin arow_nxt = 5'd0; st_nxt = S_ACHK; i_nxt = 5'd0; k_nxt = 6'd0; ph_nxt = 1'b1; end
        end
      end
      // walk rows whose basis is artificial, seek a replacement column
      S_ACHK: begin
        sub_nxt = 2'd0;
        if (ph_r) ph_nxt = 1'b0;
        else arow_nxt = arow_r + 5'd1;
        if (!ph_r && arow_r + 5'd1 >= nm_r) st_nxt = S_EMIT;
        else begin
          k_nxt = 6'd0; st_nxt = S_ASCAN;
          i_nxt = ph_r ? arow_r : arow_r + 5'd1;
          if (ph_r && nm_r == 5'd0) st_nxt = S_EMIT;
        end
        if (st_nxt == S_EMIT) i_nxt = 5'd0;
      end
      S_ASCAN: begin
        if (wb_r[i_r[3:0]] < nn_r && sub_r == 2'd0) st_nxt = S_ACHK;
        else if (k_r >= nn_r) st_nxt = S_ACHK;
        else if (sub_r != 2'd2) begin
          w_addr = sts_pkg::taddr(i_r, k_r); sub_nxt = 2'd2;
        end else begin
          sub_nxt = 2'd1;
          if ({1'b0, sts_pkg::mag(work_q)} > {24'd0, tol_r} && !in_b) begin
            prow_nxt = i_r; pcol_nxt = k_r; art_ph_nxt = 1'b1;
            st_nxt = S_PDIV; sub_nxt = 2'd0; k_nxt = 6'd0;
          end else k_nxt = k_r + 6'd1;
        end
      end
      // one result beat per constraint row
      S_EMIT: begin
        if (sub_r == 2'd0) begin
          w_addr = sts_pkg::taddr(ob_r, nv); sub_nxt = 2'd1;
        end else if (sub_r == 2'd1) begin
          f_nxt = work_q; w_addr = sts_pkg::taddr(i_r, nv); sub_nxt = 2'd2;
        end else begin
          out_valid = 1'b1; out_result_row = i_r[3:0]; out_result_basis = wb_r[i_r[3:0]];
          out_rhs_value = work_q; out_objective_value = f_r;
          out_status = sts_pkg::ST_OPTIMAL; out_last = (i_r + 5'd1 == nm_r);
          if (i_r + 5'd1 == nm_r) begin st_nxt = S_IDLE; sub_nxt = 2'd0; end
          else begin
            i_nxt = i_r + 5'd1; w_addr = sts_pkg::taddr(i_r + 5'd1, nv);
          end
        end
      end
      S_FAIL: begin
        out_valid = 1'b1; out_status = stat_r; out_last = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end
endmodule

/* hw/rtl/sts_div.sv */
// Bit-serial Q24.24 saturating divider, one quotient bit per cycle.
// Depends on sts_pkg.
module sts_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sts_pkg::div_req_t req,
  output sts_pkg::div_rsp_t rsp
);
  // dividend magnitude extended by 24 fraction bits: 72 bits
  logic [71:0] num_r, num_nxt;
  logic [48:0] rem_r, rem_nxt;
  logic [47:0] den_r, den_nxt;
  logic [71:0] quo_r, quo_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [1:0]  spec_r, spec_nxt; // 0 none, 1 zero result, 2 saturate
  logic [48:0] sh;
  logic [DW_W:0] dummy_unused;
  localparam int DW_W = 0;
  logic signed [47:0] res;

  assign dummy_unused = '0;

  always_comb begin
    num_nxt = num_r; rem_nxt = rem_r; den_nxt = den_r; quo_nxt = quo_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; neg_nxt = neg_r; done_nxt = 1'b0;
    spec_nxt = spec_r;
    sh = {rem_r[47:0], num_r[71]};
    if (req.go) begin
      num_nxt = {sts_pkg::mag(req.num), 24'd0};
      den_nxt = sts_pkg::mag(req.den);
      rem_nxt = '0; quo_nxt = '0; cnt_nxt = 7'd0;
      neg_nxt = req.num[47] ^ req.den[47];
      spec_nxt = 2'd0;
      busy_nxt = 1'b1;
      if (req.den == '0) begin
        spec_nxt = (req.num == '0) ? 2'd1 : 2'd2;
        neg_nxt  = req.num[47];
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end else if (busy_r) begin
      num_nxt = {num_r[70:0], 1'b0};
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r}; quo_nxt = {quo_r[70:0], 1'b1};
      end else begin
        rem_nxt = sh; quo_nxt = {quo_r[70:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd71) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    num_r <= num_nxt; rem_r <= rem_nxt; den_r <= den_nxt; quo_r <= quo_nxt;
    cnt_r <= cnt_nxt; neg_r <= neg_nxt; spec_r <= spec_nxt;
  end

  // integer part >= 2^23 saturates
  always_comb begin
    if (spec_r == 2'd1) res = '0;
    else if (spec_r == 2'd2) res = neg_r ? sts_pkg::QMin : sts_pkg::QMax;
    else if (quo_r[71:47] != '0) res = sts_pkg::sgn_sat({1'b1, 48'd0}, neg_r);
    else res = sts_pkg::sgn_sat({1'b0, quo_r[47:0]}, neg_r);
  end

  assign rsp.done = done_r;
  assign rsp.quo  = res;
endmodule

/* hw/rtl/sts_mul.sv */
// Registered Q24.24 saturating multiplier, split in 24-bit partial products.
// Depends on sts_pkg. Fully pipelined.
module sts_mul (
  input  logic                clk,
  input  logic signed [47:0]  a,
  input  logic signed [47:0]  b,
  output logic signed [47:0]  p
);
  logic [23:0] ha, la, hb, lb;
  logic [47:0] hh_r, hl_r, lh_r, ll_r;
  logic        neg_r, neg2_r;
  logic [49:0] sum_r;
  logic        ovf_r;

  assign ha = sts_pkg::mag(a)[47:24];
  assign la = sts_pkg::mag(a)[23:0];
  assign hb = sts_pkg::mag(b)[47:24];
  assign lb = sts_pkg::mag(b)[23:0];

  // stage 1: four partial products
  always_ff @(posedge clk) begin
    hh_r <= ha * hb; hl_r <= ha * lb; lh_r <= la * hb; ll_r <= la * lb;
    neg_r <= a[47] ^ b[47];
  end

  // stage 2: align and add
  always_ff @(posedge clk) begin
    ovf_r  <= (hh_r >= 48'd8388608);
    sum_r  <= {hh_r[25:0], 24'd0} + 50'(hl_r) + 50'(lh_r) + 50'(ll_r[47:24]);
    neg2_r <= neg_r;
  end

  // stage 3: saturate
  always_ff @(posedge clk) begin
    if (ovf_r || sum_r[49:48] != 2'b00) p <= sts_pkg::sgn_sat({1'b1, 48'd0}, neg2_r);
    else p <= sts_pkg::sgn_sat({1'b0, sum_r[47:0]}, neg2_r);
  end
endmodule
